>>> sv/pema_pkg.sv
// Package for the planar ego-motion accumulator: payload types, constants, tables.
// No dependencies.
package pema_pkg;

  localparam int DEPTH_DEFAULT  = 16;
  localparam int CORDIC_DEFAULT = 16;
  localparam int ATAN_LEN       = 30;

  localparam logic [1:0] CMD_ACC      = 2'd0;
  localparam logic [1:0] CMD_ACC_PUSH = 2'd1;
  localparam logic [1:0] CMD_PUSH_ACC = 2'd2;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518853;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q16     = 32'sd65536;
  localparam logic [15:0]        TU_RESET    = 16'd6554;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] yaw;
    logic signed [15:0] speed;
    logic [23:0]        time_step;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         entry_index;
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic [31:0]        frame_time;
    logic               last;
  } out_item_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    unique case (i)
      5'd0: r = 34'sd843314857;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043837;
      5'd3: r = 34'sd133525159;
      5'd4: r = 34'sd67021687;
      5'd5: r = 34'sd33543516;
      5'd6: r = 34'sd16775851;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194283;
      5'd9: r = 34'sd2097149;
      default: r = 34'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh07FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -36'sh080000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> sv/planar_ego_motion_accumulator.sv
// Planar ego-motion accumulator, top level; uses pema_pkg and pema_cordic.
// Accumulate: CORDIC, then a six-element matrix multiply into the accumulator.
// Push: each held entry is read, multiplied and rewritten, then the accumulator is
// appended; each entry goes out after a ring read, the last in the first idle cycle.
// Transactions: one at a time, busy high throughout. Receiver cannot stall.
// Reset: synchronous, clears accumulator to identity, ring empty; no clearing pass.
module planar_ego_motion_accumulator import pema_pkg::*; #(
  parameter int DEPTH        = DEPTH_DEFAULT,
  parameter int CORDIC_STEPS = CORDIC_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_item_t    item,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output logic        strobe,
  output out_item_t   result
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_CWAIT = 4'd1, S_AMUL = 4'd2, S_PDEC = 4'd3,
    S_PRD = 4'd4, S_PMUL = 4'd5, S_PWR = 4'd6, S_APP = 4'd7, S_ERD = 4'd8,
    S_EOUT = 4'd9, S_DONE = 4'd10, S_ESET = 4'd11;

  logic [3:0]  state;
  logic [15:0] tscale;
  in_item_t    cur;
  logic        phase;
  logic signed [31:0] acc [6];
  logic [31:0] acc_time;
  logic [AW-1:0] head;
  logic [CW-1:0] count, k;
  logic [2:0]  el;
  logic signed [31:0] mb [6];
  logic signed [31:0] ent [6];
  logic signed [31:0] res [6];

  logic [191:0]       ring_m [DEPTH];
  logic [31:0]        ring_t [DEPTH];
  logic [191:0]       rd_w, wr_w;
  logic signed [31:0] rd_m [6];
  logic [31:0]        rd_t;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_slot, wr_slot;
  logic signed [31:0] wr_m [6];
  logic [31:0]        wr_t;

  logic               c_start, c_done;
  logic signed [35:0] theta, theta_r, dd;
  logic signed [31:0] c_q, s_q;

  logic signed [31:0] ma, mbb, mc, md, me;
  logic [2:0] row0;

  assign busy = (state != S_IDLE);
  assign theta = 36'($signed({1'b0, tscale}) * item.yaw) <<< 2;
  assign dd = (36'($signed({1'b0, tscale}) * cur.speed) + 36'sd128) >>> 8;

  always_ff @(posedge clk) if (start && !busy) theta_r <= theta;

  pema_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(c_start), .angle(theta_r),
    .done(c_done), .cos_q16(c_q), .sin_q16(s_q));

  function automatic logic [AW-1:0] wrap(input logic [CW:0] v);
    logic [CW:0] r;
    r = (v >= (CW+1)'(DEPTH)) ? v - (CW+1)'(DEPTH) : v;
    return r[AW-1:0];
  endfunction

  // element el of a*b: a = left matrix, b = right matrix
  logic signed [31:0] la [6];
  logic signed [31:0] rb [6];
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      la[i] = (state == S_AMUL) ? acc[i] : ent[i];
      rb[i] = (state == S_AMUL) ? mb[i] : acc[i];
    end
    row0 = (el < 3'd3) ? 3'd0 : 3'd3;
    ma  = la[row0];
    mc  = la[row0 + 3'd1];
    mbb = rb[(el < 3'd3) ? el : el - 3'd3];
    md  = rb[((el < 3'd3) ? el : el - 3'd3) + 3'd3];
    me  = (el == 3'd2 || el == 3'd5) ? la[row0 + 3'd2] : '0;
  end

  logic signed [63:0] pr, qr;
  logic signed [31:0] er;
  logic [2:0] elr;
  logic       mv;
  logic signed [35:0] sum;
  always_comb begin
    sum = 36'(pr >>> 16) + 36'(qr >>> 16)
        + 36'({18'd0, ({2'b0, pr[15:0]} + {2'b0, qr[15:0]} + 18'h08000) >> 16})
        + 36'(er);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_w <= ring_m[rd_slot];
      rd_t <= ring_t[rd_slot];
    end
    if (wr_en) begin
      ring_m[wr_slot] <= wr_w;
      ring_t[wr_slot] <= wr_t;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      rd_m[i] = rd_w[i*32 +: 32];
      wr_w[i*32 +: 32] = wr_m[i];
    end
  end

  always_ff @(posedge clk) begin
    c_start <= 1'b0;
    strobe  <= 1'b0;
    rd_en   <= 1'b0;
    wr_en   <= 1'b0;
    mv      <= 1'b0;
    if (cfg_we) tscale <= cfg_data;
    pr <= ma * mbb;
    qr <= mc * md;
    er <= me;
    elr <= el;
    if (mv) res[elr] <= sat32(sum);
    if (rst) begin
      state <= S_IDLE;
      tscale <= TU_RESET;
      for (int i = 0; i < 6; i++) acc[i] <= (i == 0 || i == 4) ? ONE_Q16 : '0;
      acc_time <= '0;
      head <= '0;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          cur <= item;
          phase <= 1'b0;
          if (item.cmd == CMD_ACC || item.cmd == CMD_ACC_PUSH) begin
            c_start <= 1'b1;
            state <= S_CWAIT;
          end else if (item.cmd == CMD_PUSH_ACC) begin
            k <= '0;
            state <= S_PDEC;
          end
        end
        S_CWAIT: if (c_done) begin
          mb[0] <= c_q; mb[1] <= s_q; mb[2] <= sat32(-dd);
          mb[3] <= -s_q; mb[4] <= c_q; mb[5] <= '0;
          el <= '0;
          state <= S_AMUL;
        end
        S_AMUL: begin
          // issue 6 elements, then drain the multiplier pipeline
          if (el < 3'd6) begin
            mv <= 1'b1;
            el <= el + 3'd1;
          end else if (el == 3'd7) begin
            for (int i = 0; i < 6; i++) acc[i] <= res[i];
            acc_time <= (33'(acc_time) + 33'(cur.time_step) > 33'hFFFFFFFF) ? '1
                        : acc_time + 32'(cur.time_step);
            if (cur.cmd == CMD_ACC_PUSH && !phase) begin
              phase <= 1'b1;
              k <= '0;
              state <= S_PDEC;
            end else if (cur.cmd == CMD_ACC || phase) begin
              state <= (cur.cmd == CMD_ACC) ? S_IDLE : S_ESET;
            end else begin
              state <= S_IDLE;
            end
          end else el <= el + 3'd1;
        end
        S_PDEC: begin
          if (k == count) state <= S_APP;
          else begin
            rd_en <= 1'b1;
            rd_slot <= wrap((CW+1)'(head) + (CW+1)'(k));
            state <= S_PRD;
          end
        end
        S_PRD: state <= S_PMUL;
        S_PMUL: begin
          for (int i = 0; i < 6; i++) ent[i] <= rd_m[i];
          el <= 3'd0;
          state <= S_PWR;
        end
        S_PWR: begin
          if (el < 3'd6) begin
            mv <= 1'b1;
            el <= el + 3'd1;
          end else if (el == 3'd7) begin
            wr_en <= 1'b1;
            wr_slot <= rd_slot;
            wr_m <= res;
            wr_t <= rd_t;
            el <= '0;
            k <= k + 1'b1;
            state <= S_PDEC;
          end else el <= el + 3'd1;
        end
        S_APP: begin
          wr_en <= 1'b1;
          wr_m <= acc;
          wr_t <= acc_time;
          if (count < CW'(DEPTH)) begin
            wr_slot <= wrap((CW+1)'(head) + (CW+1)'(count));
            count <= count + 1'b1;
          end else begin
            wr_slot <= head;
            head <= wrap((CW+1)'(head) + (CW+1)'(1));
          end
          for (int i = 0; i < 6; i++) acc[i] <= (i == 0 || i == 4) ? ONE_Q16 : '0;
          acc_time <= '0;
          el <= '0;
          if (cur.cmd == CMD_PUSH_ACC) begin
            phase <= 1'b1;
            c_start <= 1'b1;
            state <= S_CWAIT;
          end else state <= S_ESET;
        end
        S_ESET: begin
          k <= '0;
          state <= S_ERD;
        end
        S_ERD: begin
          rd_en <= 1'b1;
          rd_slot <= wrap((CW+1)'(head) + (CW+1)'(k));
          state <= S_DONE;
        end
        S_DONE: state <= S_EOUT;
        S_EOUT: begin
          strobe <= 1'b1;
          result.entry_index <= 6'(k);
          result.m00 <= rd_m[0]; result.m01 <= rd_m[1]; result.m02 <= rd_m[2];
          result.m10 <= rd_m[3]; result.m11 <= rd_m[4]; result.m12 <= rd_m[5];
          result.frame_time <= rd_t;
          result.last <= (k + 1'b1 == count);
          k <= k + 1'b1;
          state <= (k + 1'b1 == count) ? S_IDLE : S_ERD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("ring count exceeds depth");
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy)) else $error("result without a transaction");
  a_rw: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en && wr_slot == rd_slot)) else $error("ring read-write clash");
`endif
endmodule

>>> sv/pema_cordic.sv
// Iterative CORDIC sine and cosine with range reduction, one rotation a cycle.
// Depends on pema_pkg.
module pema_cordic import pema_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [35:0]  angle,
  output logic                done,
  output logic signed [31:0]  cos_q16,
  output logic signed [31:0]  sin_q16
);
  localparam int STEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  logic signed [35:0] x, y, z;
  logic [4:0]         step;
  logic               run, neg;
  logic signed [35:0] zr, zf, xr, yr;
  logic               nf;

  always_comb begin
    zr = angle;
    if (zr > PI_Q30) zr = zr - TWO_PI_Q30;
    else if (zr < -PI_Q30) zr = zr + TWO_PI_Q30;
    nf = 1'b0;
    zf = zr;
    if (zr > HALF_PI_Q30) begin
      zf = zr - PI_Q30;
      nf = 1'b1;
    end else if (zr < -HALF_PI_Q30) begin
      zf = zr + PI_Q30;
      nf = 1'b1;
    end
    xr = neg ? -x : x;
    yr = neg ? -y : y;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      x    <= 36'(GAIN_Q30);
      y    <= '0;
      z    <= zf;
      neg  <= nf;
      step <= '0;
      run  <= 1'b1;
    end else if (run) begin
      if (32'(step) == STEPS) begin
        run     <= 1'b0;
        done    <= 1'b1;
        cos_q16 <= 32'((xr + 36'sd8192) >>> 14);
        sin_q16 <= 32'((yr + 36'sd8192) >>> 14);
      end else begin
        if (z >= 0) begin
          x <= x - (y >>> step);
          y <= y + (x >>> step);
          z <= z - 36'(atan_q30(step));
        end else begin
          x <= x + (y >>> step);
          y <= y - (x >>> step);
          z <= z + 36'(atan_q30(step));
        end
        step <= step + 5'd1;
      end
    end
  end
endmodule
